// ----- rtl/core/websocket_client_frame_encoder_assert.svh -----
// Assertion macros for the WebSocket client frame encoder.
// Needs clk and arst_n in the scope that uses them.
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define WSCFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSCFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/wscfe_pkg.sv -----
// Shared types, codes and constants for the WebSocket client frame encoder.
// No dependencies.
`timescale 1ns / 1ps

package wscfe_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_BIN  = 2'd1;
	localparam logic [1:0] MODE_DATA = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_NO_FRAME = 2'd2;

	localparam logic [7:0] OP_TEXT   = 8'h81;
	localparam logic [7:0] OP_BIN    = 8'h82;
	localparam logic [7:0] LEN_EXT16 = 8'hFE;
	localparam logic [7:0] LEN_EXT64 = 8'hFF;

	localparam logic [63:0] SMALL_MAX = 64'd125;
	localparam logic [63:0] MED_MAX   = 64'd65535;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic frame_open;
		logic left_zero;
		logic hdr_busy;
	} core_stat_t;

	function automatic logic [7:0] mask_byte(input logic bin, input logic [1:0] pos);
		logic [7:0] b;
		if (bin) begin
			case (pos)
				2'd0:    b = 8'h12;
				2'd1:    b = 8'h34;
				2'd2:    b = 8'h56;
				default: b = 8'h78;
			endcase
		end else begin
			case (pos)
				2'd0:    b = 8'h11;
				2'd1:    b = 8'h22;
				2'd2:    b = 8'h33;
				default: b = 8'h44;
			endcase
		end
		return b;
	endfunction

endpackage

// ----- rtl/core/websocket_client_frame_encoder.sv -----
// Top level of the masked WebSocket client frame encoder.
// Depends on wscfe_pkg, wscfe_core, wscfe_out_reg and the assertion header.
//
//  channel | dir | tdata                              | tuser     | tlast
//  s_      | in  | [31:0] frame_length, [39:32] byte | [1:0] mode| -
//  m_      | out | [7:0] out_byte                     | [1:0] stat| last
//
// Payload and ignored items are taken one per cycle, back to back, payload items only
// while the output is not stalled. A start item holds the input for its 1, 6, 8 or 14
// results, one per header byte, as the header sequencer walks the byte index.
// Output register stalls propagate to the input in the same cycle.
// arst_n clears all valid and frame state; no clearing pass.
`timescale 1ns / 1ps

module websocket_client_frame_encoder #(
	parameter int LENGTH_BITS = wscfe_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] frame_length, [39:32] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	`include "websocket_client_frame_encoder_assert.svh"

	logic                  res_valid;
	logic                  res_ready;
	wscfe_pkg::result_t    res;
	wscfe_pkg::result_t    out_res;
	wscfe_pkg::core_stat_t stat;

	wscfe_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_length (s_tdata[31:0]),
		.in_data   (s_tdata[39:32]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.stat      (stat)
	);

	wscfe_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.out_byte;
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

	`WSCFE_ASSERT_NOW(a_closed_empty, !stat.frame_open, stat.left_zero, "closed frame with bytes left")
	`WSCFE_ASSERT_NEXT(a_hdr_stall, s_tvalid && s_tready, !stat.hdr_busy, "input taken mid header")
	`WSCFE_ASSERT_NOW(a_err_clean, m_tvalid && (m_tuser != wscfe_pkg::ST_OK), !m_tlast && (m_tdata == 8'd0), "error result with data")
	`WSCFE_ASSERT_NEXT(a_open_after_take, s_tvalid && s_tready && (s_tuser == wscfe_pkg::MODE_NONE), !stat.hdr_busy, "ignored item started header")

endmodule

// ----- rtl/core/wscfe_core.sv -----
// Input register, header byte sequencer and frame state of the encoder.
// Depends on wscfe_pkg.
`timescale 1ns / 1ps

module wscfe_core #(
	parameter int LENGTH_BITS = wscfe_pkg::LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_mode,
	input  logic [31:0]          in_length,
	input  logic [7:0]           in_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output wscfe_pkg::result_t   res,
	output wscfe_pkg::core_stat_t stat
);

	localparam logic [63:0] LenMask = {64{1'b1}} >> (64 - LENGTH_BITS);

	logic                   valid_s1;
	logic [1:0]             mode_s1;
	logic [31:0]            length_s1;
	logic [7:0]             data_s1;

	logic [3:0]             idx_q;
	logic [LENGTH_BITS-1:0] bytes_left_q;
	logic [1:0]             mask_pos_q;
	logic                   binary_key_q;
	logic                   frame_open_q;

	logic [63:0]            len64;
	logic [LENGTH_BITS-1:0] left_dec;
	logic                   is_start;
	logic                   too_long;
	logic                   small_len;
	logic                   med_len;
	logic [3:0]             last_idx;
	logic [3:0]             mask_start;
	logic [2:0]             bsel;
	logic [7:0]             hdr_byte;
	logic                   is_final;
	logic                   take;
	logic                   item_done;

	assign len64     = 64'(length_s1) & LenMask;
	assign left_dec  = bytes_left_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
	assign is_start  = (mode_s1 == wscfe_pkg::MODE_TEXT) || (mode_s1 == wscfe_pkg::MODE_BIN);
	assign too_long  = (mode_s1 == wscfe_pkg::MODE_TEXT) && (len64 > wscfe_pkg::MED_MAX);
	assign small_len = len64 <= wscfe_pkg::SMALL_MAX;
	assign med_len   = !small_len && (len64 <= wscfe_pkg::MED_MAX);

	always_comb begin
		if (too_long)       last_idx = 4'd0;
		else if (small_len) last_idx = 4'd5;
		else if (med_len)   last_idx = 4'd7;
		else                last_idx = 4'd13;
	end

	assign mask_start = small_len ? 4'd2 : (med_len ? 4'd4 : 4'd10);
	assign bsel       = 3'(4'd9 - idx_q);

	always_comb begin
		if (idx_q == 4'd0) begin
			hdr_byte = mode_s1[0] ? wscfe_pkg::OP_BIN : wscfe_pkg::OP_TEXT;
		end else if (idx_q >= mask_start) begin
			hdr_byte = wscfe_pkg::mask_byte(mode_s1[0], 2'(idx_q - mask_start));
		end else if (idx_q == 4'd1) begin
			if (small_len)    hdr_byte = {1'b1, len64[6:0]};
			else if (med_len) hdr_byte = wscfe_pkg::LEN_EXT16;
			else              hdr_byte = wscfe_pkg::LEN_EXT64;
		end else if (med_len) begin
			hdr_byte = (idx_q == 4'd2) ? len64[15:8] : len64[7:0];
		end else begin
			hdr_byte = len64[bsel*8 +: 8];
		end
	end

	always_comb begin
		res = '0;
		if (is_start) begin
			if (too_long) begin
				res.status = wscfe_pkg::ST_TOO_LONG;
			end else begin
				res.out_byte = hdr_byte;
				res.last     = (idx_q == last_idx) && (len64 == 64'd0);
			end
		end else if (frame_open_q) begin
			res.out_byte = data_s1 ^ wscfe_pkg::mask_byte(binary_key_q, mask_pos_q);
			res.last     = left_dec == '0;
		end else begin
			res.status = wscfe_pkg::ST_NO_FRAME;
		end
	end

	assign res_valid = valid_s1 && (mode_s1 != wscfe_pkg::MODE_NONE);
	assign take      = res_valid && res_ready;
	assign is_final  = !is_start || (idx_q == last_idx);
	assign item_done = valid_s1 && ((mode_s1 == wscfe_pkg::MODE_NONE) || (take && is_final));
	assign in_ready  = !valid_s1 || item_done;

	assign stat.frame_open = frame_open_q;
	assign stat.left_zero  = bytes_left_q == '0;
	assign stat.hdr_busy   = idx_q != 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1   <= in_mode;
			length_s1 <= in_length;
			data_s1   <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= 4'd0;
			bytes_left_q <= '0;
			mask_pos_q   <= 2'd0;
			binary_key_q <= 1'b0;
			frame_open_q <= 1'b0;
		end else begin
			if (item_done) begin
				idx_q <= 4'd0;
			end else if (take) begin
				idx_q <= idx_q + 4'd1;
			end
			if (item_done && is_start) begin
				frame_open_q <= 1'b0;
				bytes_left_q <= '0;
				mask_pos_q   <= 2'd0;
				if (!too_long) begin
					binary_key_q <= mode_s1[0];
					if (len64 != 64'd0) begin
						bytes_left_q <= len64[LENGTH_BITS-1:0];
						frame_open_q <= 1'b1;
					end
				end
			end else if (item_done && (mode_s1 == wscfe_pkg::MODE_DATA) && frame_open_q) begin
				mask_pos_q   <= mask_pos_q + 2'd1;
				bytes_left_q <= left_dec;
				if (left_dec == '0) frame_open_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/wscfe_out_reg.sv -----
// Output register stage of the encoder, decoupling the core from the sink.
// Depends on wscfe_pkg.
`timescale 1ns / 1ps

module wscfe_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wscfe_pkg::result_t in_res,
	output logic               out_valid,
	input  logic               out_ready,
	output wscfe_pkg::result_t out_res
);

	logic               valid_q;
	wscfe_pkg::result_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule
